// ===== rtl/bsim_pkg.sv =====
// shared types and constants of the bank switch irq mapper
`timescale 1ns / 1ps
`default_nettype none
package bsim_pkg;

   // input field widths
   localparam int ADDR_W = 16;
   localparam int BYTE_W = 8;
   localparam int CYC_W  = 4;
   localparam int CYC_MAX = (1 << CYC_W) - 1;
   localparam int SLOT_W = 3;
   localparam int MIRROR_W = 2;

   // bus decode
   localparam logic [ADDR_W-1:0] DECODE_MASK  = 16'hF010;
   localparam logic [ADDR_W-1:0] PAT_LOW      = 16'hA000;
   localparam logic [ADDR_W-1:0] PAT_HIGH     = 16'hDFFF;
   localparam logic [3:0]        PAT_NIBBLE   = 4'hA;
   localparam logic [ADDR_W-1:0] ADDR_PRG0    = 16'h8000;
   localparam logic [ADDR_W-1:0] ADDR_PRG1    = 16'h8010;
   localparam logic [ADDR_W-1:0] ADDR_PRG2    = 16'h9000;
   localparam logic [ADDR_W-1:0] ADDR_MIRROR  = 16'hE000;
   localparam logic [ADDR_W-1:0] ADDR_RELOAD  = 16'hE010;
   localparam logic [ADDR_W-1:0] ADDR_CONTROL = 16'hF000;
   localparam logic [ADDR_W-1:0] ADDR_ACK     = 16'hF010;

   // control write bits
   localparam int CTRL_ACK_ENABLE = 0;
   localparam int CTRL_ENABLE     = 1;
   localparam int CTRL_PER_CYCLE  = 2;

   // counter and prescaler
   localparam int DOTS_PER_LINE = 341;
   localparam logic [BYTE_W-1:0] COUNT_TOP = 8'hFF;
   localparam logic [BYTE_W-1:0] RAM_BANK_MASK = 8'h07;

   // configuration register indexes
   localparam logic CSR_PATTERN_IS_RAM = 1'b0;
   localparam logic CSR_MIRROR_LOCK    = 1'b1;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_PRG0,
      CMD_PRG1,
      CMD_PRG2,
      CMD_MIRROR,
      CMD_RELOAD,
      CMD_CONTROL,
      CMD_ACK,
      CMD_PATTERN,
      CMD_ADVANCE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [BYTE_W-1:0]     value;
      logic [SLOT_W-1:0]     slot;
      logic [CYC_W-1:0]      cycles;
   } cmd_type;

   typedef struct packed {
      logic pattern_is_ram;
      logic mirror_locked;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   pattern_bank;
      logic [SLOT_W-1:0]   pattern_slot;
      logic                pattern_written;
      logic [MIRROR_W-1:0] mirror_mode;
      logic [BYTE_W-1:0]   prg_bank_third;
      logic [BYTE_W-1:0]   prg_bank_second;
      logic [BYTE_W-1:0]   prg_bank_first;
      logic                irq_line;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/bank_switch_irq_mapper.sv =====
// top level of the bank switch irq mapper: ports, configuration and packing
// a bus write passes the queue entry register and then the result register;
// a time advance in per-cycle mode ticks once per clipped cycle; in scanline mode
// it ticks per 341 dots at three per clipped cycle, at most once per advance
// throughput: one command at a time, one counter tick per cycle; bus writes sustain
// one per cycle while idle with output free; synchronous reset spares result/queue data
`timescale 1ns / 1ps
`default_nettype none
module bank_switch_irq_mapper #(
   parameter int MAX_CYCLES_PER_ITEM = 15,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,   // operation
   input  wire logic [31:0] req_tdata,   // address, data, cycle_count, zero fill
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // irq_line, prg_bank_first, prg_bank_second,
                                         // prg_bank_third, mirror_mode, pattern_written,
                                         // pattern_slot, pattern_bank, zero fill
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic        csr_wdata
);

   bsim_pkg::cfg_type cfg_ff, cfg_in;
   bsim_pkg::cmd_type push_cmd;
   bsim_pkg::cmd_type pop_cmd;
   bsim_pkg::rsp_type rsp;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_empty;

   // configuration registers, to be written only while the block is idle; left to the user
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            bsim_pkg::CSR_PATTERN_IS_RAM: cfg_in.pattern_is_ram = csr_wdata;
            bsim_pkg::CSR_MIRROR_LOCK:    cfg_in.mirror_locked  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // decode of each transfer into a command
   bsim_front #(
      .MAX_CYCLES_PER_ITEM(MAX_CYCLES_PER_ITEM)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // short queue so front and back stall independently
   bsim_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   // bank state, irq counter and the result register
   bsim_back #(
      .MAX_CYCLES_PER_ITEM(MAX_CYCLES_PER_ITEM)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .cmd        (pop_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   // first field in the lowest bits
   assign rsp_tdata = {1'b0,
                       rsp.pattern_bank,
                       rsp.pattern_slot,
                       rsp.pattern_written,
                       rsp.mirror_mode,
                       rsp.prg_bank_third,
                       rsp.prg_bank_second,
                       rsp.prg_bank_first,
                       rsp.irq_line};

endmodule
`default_nettype wire

// ===== rtl/bsim_front.sv =====
// front end: accepts bus writes and time advances and classifies them
`timescale 1ns / 1ps
`default_nettype none
module bsim_front #(
   parameter int MAX_CYCLES_PER_ITEM = 15
) (
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic                     req_tuser,    // operation
   input  wire logic [31:0]              req_tdata,    // address, data, cycle_count
   input  wire logic                     q_full,
   output logic                          push,
   output bsim_pkg::cmd_type             push_cmd
);

   logic [bsim_pkg::ADDR_W-1:0] address;
   logic [bsim_pkg::BYTE_W-1:0] data;
   logic [bsim_pkg::CYC_W-1:0]  cycle_count;
   logic [bsim_pkg::ADDR_W-1:0] reg_sel;
   logic [3:0]                  pat_row;

   assign address     = req_tdata[15:0];
   assign data        = req_tdata[23:16];
   assign cycle_count = req_tdata[27:24];
   assign reg_sel     = address & bsim_pkg::DECODE_MASK;
   assign pat_row     = address[15:12] - bsim_pkg::PAT_NIBBLE;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   always_comb begin
      push_cmd.kind   = bsim_pkg::CMD_NONE;
      push_cmd.value  = data;
      push_cmd.slot   = '0;
      push_cmd.cycles = '0;
      if (req_tuser) begin
         push_cmd.kind = bsim_pkg::CMD_ADVANCE;
         // long advances clip to the per-item limit
         if ({28'd0, cycle_count} > 32'(MAX_CYCLES_PER_ITEM)) begin
            push_cmd.cycles = bsim_pkg::CYC_W'(MAX_CYCLES_PER_ITEM);
         end else begin
            push_cmd.cycles = cycle_count;
         end
      end else if (address inside {[bsim_pkg::PAT_LOW:bsim_pkg::PAT_HIGH]}) begin
         push_cmd.kind = bsim_pkg::CMD_PATTERN;
         push_cmd.slot = {pat_row[1:0], address[4]};
      end else begin
         case (reg_sel)
            bsim_pkg::ADDR_PRG0:    push_cmd.kind = bsim_pkg::CMD_PRG0;
            bsim_pkg::ADDR_PRG1:    push_cmd.kind = bsim_pkg::CMD_PRG1;
            bsim_pkg::ADDR_PRG2:    push_cmd.kind = bsim_pkg::CMD_PRG2;
            bsim_pkg::ADDR_MIRROR:  push_cmd.kind = bsim_pkg::CMD_MIRROR;
            bsim_pkg::ADDR_RELOAD:  push_cmd.kind = bsim_pkg::CMD_RELOAD;
            bsim_pkg::ADDR_CONTROL: push_cmd.kind = bsim_pkg::CMD_CONTROL;
            bsim_pkg::ADDR_ACK:     push_cmd.kind = bsim_pkg::CMD_ACK;
            default:                push_cmd.kind = bsim_pkg::CMD_NONE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== rtl/bsim_queue.sv =====
// command queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none
module bsim_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire bsim_pkg::cmd_type  push_cmd,
   output logic                    full,
   input  wire logic               pop,
   output bsim_pkg::cmd_type       pop_cmd,
   output logic                    empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bsim_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

   no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");

endmodule
`default_nettype wire

// ===== rtl/bsim_back.sv =====
// back end: bank registers, irq counter sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
module bsim_back #(
   parameter int MAX_CYCLES_PER_ITEM = 15
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bsim_pkg::cfg_type  cfg,
   input  wire logic               q_empty,
   input  wire bsim_pkg::cmd_type  cmd,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output bsim_pkg::rsp_type       rsp
);

   localparam int EFF_MAX = (MAX_CYCLES_PER_ITEM < bsim_pkg::CYC_MAX) ?
                            MAX_CYCLES_PER_ITEM : bsim_pkg::CYC_MAX;
   localparam int PW = $clog2(bsim_pkg::DOTS_PER_LINE + 3 * EFF_MAX);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [bsim_pkg::BYTE_W-1:0]   prg0_ff, prg0_in;
   logic [bsim_pkg::BYTE_W-1:0]   prg1_ff, prg1_in;
   logic [bsim_pkg::BYTE_W-1:0]   prg2_ff, prg2_in;
   logic [bsim_pkg::MIRROR_W-1:0] mirror_ff, mirror_in;
   logic [bsim_pkg::BYTE_W-1:0]   reload_ff, reload_in;
   logic [bsim_pkg::BYTE_W-1:0]   count_ff, count_in;
   logic                          enabled_ff, enabled_in;
   logic                          ack_enable_ff, ack_enable_in;
   logic                          per_cycle_ff, per_cycle_in;
   logic [PW-1:0]                 pre_ff, pre_in;
   logic                          irq_ff, irq_in;
   logic [bsim_pkg::CYC_W-1:0]    steps_ff, steps_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bsim_pkg::rsp_type             rsp_ff, rsp_in;

   logic                          out_free;
   logic                          emit;
   logic                          tick;
   logic                          res_written;
   logic [bsim_pkg::SLOT_W-1:0]   res_slot;
   logic [bsim_pkg::BYTE_W-1:0]   res_bank;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      prg0_in       = prg0_ff;
      prg1_in       = prg1_ff;
      prg2_in       = prg2_ff;
      mirror_in     = mirror_ff;
      reload_in     = reload_ff;
      enabled_in    = enabled_ff;
      ack_enable_in = ack_enable_ff;
      per_cycle_in  = per_cycle_ff;
      pre_in        = pre_ff;
      steps_in      = steps_ff;
      pop           = 1'b0;
      emit          = 1'b0;
      tick          = 1'b0;
      res_written   = 1'b0;
      res_slot      = '0;
      res_bank      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && out_free) begin
               pop = 1'b1;
               emit = 1'b1;
               case (cmd.kind)
                  bsim_pkg::CMD_PRG0:   prg0_in = cmd.value;
                  bsim_pkg::CMD_PRG1:   prg1_in = cmd.value;
                  bsim_pkg::CMD_PRG2:   prg2_in = cmd.value;
                  bsim_pkg::CMD_MIRROR: begin
                     if (!cfg.mirror_locked) begin
                        mirror_in = cmd.value[bsim_pkg::MIRROR_W-1:0];
                     end
                  end
                  bsim_pkg::CMD_RELOAD: reload_in = cmd.value;
                  bsim_pkg::CMD_CONTROL: begin
                     pre_in        = '0;
                     per_cycle_in  = cmd.value[bsim_pkg::CTRL_PER_CYCLE];
                     enabled_in    = cmd.value[bsim_pkg::CTRL_ENABLE];
                     ack_enable_in = cmd.value[bsim_pkg::CTRL_ACK_ENABLE];
                  end
                  bsim_pkg::CMD_ACK: enabled_in = ack_enable_ff;
                  bsim_pkg::CMD_PATTERN: begin
                     res_written = 1'b1;
                     res_slot    = cmd.slot;
                     res_bank    = cfg.pattern_is_ram ?
                                   (cmd.value & bsim_pkg::RAM_BANK_MASK) : cmd.value;
                  end
                  bsim_pkg::CMD_ADVANCE: begin
                     // disabled counter: nothing moves, result right away
                     if (enabled_ff) begin
                        emit     = 1'b0;
                        state_in = ST_RUN;
                        if (per_cycle_ff) begin
                           steps_in = cmd.cycles;
                        end else begin
                           pre_in = pre_ff + PW'(cmd.cycles) + PW'({cmd.cycles, 1'b0});
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            // one counter tick per cycle
            if (per_cycle_ff && steps_ff != '0) begin
               tick     = 1'b1;
               steps_in = steps_ff - 1'b1;
            end else if (!per_cycle_ff && pre_ff >= PW'(bsim_pkg::DOTS_PER_LINE)) begin
               tick   = 1'b1;
               pre_in = pre_ff - PW'(bsim_pkg::DOTS_PER_LINE);
            end else if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // irq counter and line
   always_comb begin
      count_in = count_ff;
      irq_in   = irq_ff;
      if (pop && cmd.kind == bsim_pkg::CMD_CONTROL) begin
         irq_in = 1'b0;
         if (cmd.value[bsim_pkg::CTRL_ENABLE]) begin
            count_in = reload_ff;
         end
      end else if (pop && cmd.kind == bsim_pkg::CMD_ACK) begin
         irq_in = 1'b0;
      end else if (tick) begin
         if (count_ff == bsim_pkg::COUNT_TOP) begin
            count_in = reload_ff;
            irq_in   = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_in.irq_line        = irq_in;
         rsp_in.prg_bank_first  = prg0_in;
         rsp_in.prg_bank_second = prg1_in;
         rsp_in.prg_bank_third  = prg2_in;
         rsp_in.mirror_mode     = mirror_in;
         rsp_in.pattern_written = res_written;
         rsp_in.pattern_slot    = res_slot;
         rsp_in.pattern_bank    = res_bank;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prg0_ff       <= '0;
         prg1_ff       <= '0;
         prg2_ff       <= '0;
         mirror_ff     <= '0;
         reload_ff     <= '0;
         count_ff      <= '0;
         enabled_ff    <= 1'b0;
         ack_enable_ff <= 1'b0;
         per_cycle_ff  <= 1'b0;
         pre_ff        <= '0;
         irq_ff        <= 1'b0;
         steps_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prg0_ff       <= prg0_in;
         prg1_ff       <= prg1_in;
         prg2_ff       <= prg2_in;
         mirror_ff     <= mirror_in;
         reload_ff     <= reload_in;
         count_ff      <= count_in;
         enabled_ff    <= enabled_in;
         ack_enable_ff <= ack_enable_in;
         per_cycle_ff  <= per_cycle_in;
         pre_ff        <= pre_in;
         irq_ff        <= irq_in;
         steps_ff      <= steps_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   irq_rise_from_wrap: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_ff) |-> ($past(count_ff) == bsim_pkg::COUNT_TOP && $past(tick)))
      else $error("irq raised without a counter wrap");

   no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !emit)
      else $error("pending result overwritten");

   prescaler_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && emit && !per_cycle_ff) |->
      (pre_ff < PW'(bsim_pkg::DOTS_PER_LINE)))
      else $error("scanline advance finished with prescaler out of range");

endmodule
`default_nettype wire
